/* rtl/kds_pkg.sv */
// Shared types and constants for the keypad debounce scanner.
package kds_pkg;

    localparam int MAX_KEYS = 16;
    localparam int ROWS     = 8;
    localparam int COLUMNS  = 8;
    localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam logic [15:0] DEBOUNCE_RST = 16'd50;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;

    typedef enum logic [2:0] {
        PH_REST            = 3'd0,
        PH_CLAMPED         = 3'd1,
        PH_PRESSED_CLAMPED = 3'd2,
        PH_PRESSED         = 3'd3,
        PH_ERROR           = 3'd4,
        PH_IDLE            = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  column;
        logic [7:0]  code;
        phase_t      phase;
        logic [31:0] start_ms;
    } key_entry_t;

    typedef struct packed {
        logic        run;
        logic        take_pressed;
        logic [31:0] now_ms;
        logic [63:0] levels;
        logic [15:0] debounce_ms;
    } fsm_ctl_t;

endpackage

/* rtl/keypad_debounce_scanner.sv */
// Keypad debounce scanner: key table in memory, walked one entry per cycle.
//
// Input channel (in_valid/in_ready) takes one request beat: add key, update
// all keys, or get the first pressed key. Output channel (out_valid/out_ready)
// returns one result beat per request.
// An add or the unused code goes straight to the done state and loads its
// result once the output register is free. Update and get read the table one
// entry per cycle through the memory's read port, with the write-back of each
// entry in the cycle after its read; a get stops at the first pressed key.
// in_ready returns as the result loads into the output register. One request
// is in work at a time.
// A finished result sits in the output register; the next request is accepted
// while it waits. If the receiver stalls with a result still held, a second
// finished result waits in the block and no further request is taken.
// cfg_wr_en/cfg_wr_data write the debounce_ms register.
// Reset empties the table (key_count 0) and sets debounce_ms to 50; no
// clearing pass is needed since only entries below key_count are read.
module keypad_debounce_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  new_key_code,
    input  logic [2:0]  new_key_row,
    input  logic [2:0]  new_key_column,
    input  logic        update_first,
    input  logic [31:0] now_ms,
    input  logic [63:0] line_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        add_accepted,
    output logic        key_found,
    output logic [7:0]  found_code
);
    import kds_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic              proc_valid_reg;
    logic [IDX_W-1:0]  proc_idx_reg;
    logic [1:0]        req_reg;
    logic              upd_reg;
    logic [31:0]       now_reg;
    logic [63:0]       levels_reg;
    logic [15:0]       debounce_reg;
    logic              res_add_reg;
    logic              res_found_reg;
    logic [7:0]        res_code_reg;
    logic              out_valid_reg;
    logic              out_add_reg;
    logic              out_found_reg;
    logic [7:0]        out_code_reg;

    logic       in_fire;
    logic       add_ok;
    logic       hit;
    logic       issue_ok;
    logic       scan_end;
    logic       out_free;
    logic       out_load;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;
    key_entry_t wr_data;
    key_entry_t new_entry;
    key_entry_t rd_data;
    key_entry_t fsm_out;
    logic       fsm_found;
    fsm_ctl_t   fsm_ctl;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    assign add_ok = (count_reg < CNT_W'(MAX_KEYS))
                 && ({1'b0, new_key_row} < 4'(ROWS))
                 && ({1'b0, new_key_column} < 4'(COLUMNS));

    assign fsm_ctl.run          = (req_reg == REQ_UPDATE) || upd_reg;
    assign fsm_ctl.take_pressed = (req_reg == REQ_GET);
    assign fsm_ctl.now_ms       = now_reg;
    assign fsm_ctl.levels       = levels_reg;
    assign fsm_ctl.debounce_ms  = debounce_reg;

    assign hit      = proc_valid_reg && fsm_found;
    assign issue_ok = (state_reg == ST_SCAN) && (issue_reg < count_reg) && !hit;
    assign scan_end = (state_reg == ST_SCAN) && (hit || (!issue_ok && !proc_valid_reg));

    always_comb
    begin
        new_entry.row      = new_key_row;
        new_entry.column   = new_key_column;
        new_entry.code     = new_key_code;
        new_entry.phase    = PH_REST;
        new_entry.start_ms = 32'd0;
        if (proc_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = proc_idx_reg;
            wr_data = fsm_out;
        end
        else
        begin
            wr_en   = in_fire && (req_type == REQ_ADD) && add_ok;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = new_entry;
        end
    end

    kds_key_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue_ok),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    kds_key_fsm u_fsm (
        .entry_in  (rd_data),
        .ctl       (fsm_ctl),
        .entry_out (fsm_out),
        .found     (fsm_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            req_reg        <= REQ_ADD;
            upd_reg        <= 1'b0;
            now_reg        <= '0;
            levels_reg     <= '0;
            debounce_reg   <= DEBOUNCE_RST;
            out_valid_reg  <= 1'b0;
            out_add_reg    <= 1'b0;
            out_found_reg  <= 1'b0;
            out_code_reg   <= '0;
            res_add_reg    <= 1'b0;
            res_found_reg  <= 1'b0;
            res_code_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_reg <= cfg_wr_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_add_reg   <= res_add_reg;
                out_found_reg <= res_found_reg;
                out_code_reg  <= res_code_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            proc_valid_reg <= issue_ok;
            proc_idx_reg   <= issue_reg[IDX_W-1:0];
            if (issue_ok)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_reg       <= req_type;
                        upd_reg       <= update_first;
                        now_reg       <= now_ms;
                        levels_reg    <= line_levels;
                        issue_reg     <= '0;
                        res_add_reg   <= (req_type == REQ_ADD) && add_ok;
                        res_found_reg <= 1'b0;
                        res_code_reg  <= '0;
                        if (req_type == REQ_UPDATE || req_type == REQ_GET)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                            if (req_type == REQ_ADD && add_ok)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        state_reg <= ST_DONE;
                        if (hit)
                        begin
                            res_found_reg <= 1'b1;
                            res_code_reg  <= rd_data.code;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign add_accepted = out_add_reg;
    assign key_found    = out_found_reg;
    assign found_code   = out_code_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEYS))
        else $error("key count above table size");

    a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !proc_valid_reg)
        else $error("table write-back pending while idle");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_add_reg && out_found_reg))
        else $error("add and found both set in one beat");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_code_reg == 8'd0))
        else $error("nonzero code without a found key");

    a_count_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(in_fire) && $past(req_type) == REQ_ADD))
        else $error("key count changed outside an add");
`endif

endmodule

/* rtl/kds_key_ram.sv */
// Key table memory: one write port, one registered read port.
module kds_key_ram (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [kds_pkg::IDX_W-1:0] wr_addr,
    input  kds_pkg::key_entry_t      wr_data,
    input  logic                     rd_en,
    input  logic [kds_pkg::IDX_W-1:0] rd_addr,
    output kds_pkg::key_entry_t      rd_data
);
    import kds_pkg::*;

    key_entry_t mem [MAX_KEYS];
    key_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kds_key_fsm.sv */
// Per-key debounce state update and pressed-key pickup.
module kds_key_fsm (
    input  kds_pkg::key_entry_t entry_in,
    input  kds_pkg::fsm_ctl_t   ctl,
    output kds_pkg::key_entry_t entry_out,
    output logic                found
);
    import kds_pkg::*;

    logic       high;
    logic [31:0] elapsed;
    key_entry_t upd;

    assign high    = ctl.levels[{entry_in.row, entry_in.column}];
    assign elapsed = ctl.now_ms - entry_in.start_ms;

    always_comb
    begin
        upd = entry_in;
        if (ctl.run)
        begin
            unique case (entry_in.phase)
                PH_REST:
                begin
                    if (high)
                    begin
                        upd.start_ms = ctl.now_ms;
                        upd.phase    = PH_CLAMPED;
                    end
                end
                PH_CLAMPED:
                begin
                    if (high)
                    begin
                        if (elapsed > {16'd0, ctl.debounce_ms})
                        begin
                            upd.start_ms = 32'd0;
                            upd.phase    = PH_PRESSED_CLAMPED;
                        end
                    end
                    else
                    begin
                        upd.start_ms = 32'd0;
                        upd.phase    = PH_REST;
                    end
                end
                PH_PRESSED_CLAMPED:
                begin
                    if (!high)
                    begin
                        upd.phase = PH_PRESSED;
                    end
                end
                PH_ERROR:
                begin
                    if (high)
                    begin
                        upd.start_ms = ctl.now_ms;
                        upd.phase    = PH_CLAMPED;
                    end
                    else
                    begin
                        upd.phase = PH_REST;
                    end
                end
                PH_PRESSED, PH_IDLE:
                begin
                    upd = entry_in;
                end
                default:
                begin
                    upd.start_ms = 32'd0;
                    upd.phase    = PH_ERROR;
                end
            endcase
        end

        found     = ctl.take_pressed && (upd.phase == PH_PRESSED);
        entry_out = upd;
        if (found)
        begin
            entry_out.phase = PH_REST;
        end
    end

endmodule

/* tb/sv/keypad_debounce_scanner_test.sv */
// Self-checking testbench: key table scoreboard, randomized request and reply pacing.
module keypad_debounce_scanner_test;
    import kds_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_MAX = 17;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 90;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  code;
        logic [2:0]  row;
        logic [2:0]  column;
        logic        upd;
        logic [31:0] now;
        logic [63:0] levels;
        logic        hold;
    } key_request_t;

    typedef struct packed {
        logic       added;
        logic       found;
        logic [7:0] code;
    } key_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [7:0]  new_key_code = '0;
    logic [2:0]  new_key_row = '0;
    logic [2:0]  new_key_column = '0;
    logic        update_first = 1'b0;
    logic [31:0] now_ms = '0;
    logic [63:0] line_levels = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        add_accepted;
    logic        key_found;
    logic [7:0]  found_code;

    // key table scoreboard
    logic [15:0] dbn_ms = DEBOUNCE_RST;
    int unsigned tbl_count = 0;
    logic [2:0]  tbl_row   [MAX_KEYS];
    logic [2:0]  tbl_col   [MAX_KEYS];
    logic [7:0]  tbl_code  [MAX_KEYS];
    phase_t      tbl_phase [MAX_KEYS];
    logic [31:0] tbl_start [MAX_KEYS];

    // request generator state
    logic [31:0] sim_ms = '0;
    logic [63:0] levels_now = '0;
    logic [5:0]  gen_spot [MAX_KEYS];
    int          gen_keys = 0;

    key_request_t requests_waiting[$];
    key_reply_t   replies_due[$];
    int requests_queued = 0;
    int replies_seen = 0;
    int errors = 0;
    int adds_taken = 0;
    int presses_returned = 0;
    int quiet = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    logic req_taken = 1'b0;
    logic reply_taken = 1'b0;

    keypad_debounce_scanner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .new_key_code   (new_key_code),
        .new_key_row    (new_key_row),
        .new_key_column (new_key_column),
        .update_first   (update_first),
        .now_ms         (now_ms),
        .line_levels    (line_levels),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .add_accepted   (add_accepted),
        .key_found      (key_found),
        .found_code     (found_code)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void advance_key(int k, logic [31:0] t, logic [63:0] lv);
        logic        high;
        logic [31:0] held_ms;
        high = lv[{tbl_row[k], tbl_col[k]}];
        held_ms = t - tbl_start[k];
        case (tbl_phase[k])
            PH_REST:
                if (high)
                begin
                    tbl_start[k] = t;
                    tbl_phase[k] = PH_CLAMPED;
                end
            PH_CLAMPED:
                if (!high)
                begin
                    tbl_start[k] = '0;
                    tbl_phase[k] = PH_REST;
                end
                else if (held_ms > {16'd0, dbn_ms})
                begin
                    tbl_start[k] = '0;
                    tbl_phase[k] = PH_PRESSED_CLAMPED;
                end
            PH_PRESSED_CLAMPED:
                if (!high)
                    tbl_phase[k] = PH_PRESSED;
            PH_ERROR:
                if (high)
                begin
                    tbl_start[k] = t;
                    tbl_phase[k] = PH_CLAMPED;
                end
                else
                    tbl_phase[k] = PH_REST;
            PH_PRESSED, PH_IDLE:
                ;
            default:
            begin
                tbl_start[k] = '0;
                tbl_phase[k] = PH_ERROR;
            end
        endcase
    endfunction

    function automatic key_reply_t serve_request(key_request_t rq);
        key_reply_t rp;
        rp = '0;
        case (rq.req)
            REQ_ADD:
                if (tbl_count < MAX_KEYS && rq.row < ROWS && rq.column < COLUMNS)
                begin
                    tbl_row[tbl_count] = rq.row;
                    tbl_col[tbl_count] = rq.column;
                    tbl_code[tbl_count] = rq.code;
                    tbl_phase[tbl_count] = PH_REST;
                    tbl_start[tbl_count] = '0;
                    tbl_count++;
                    rp.added = 1'b1;
                end
            REQ_UPDATE:
                for (int i = 0; i < tbl_count; i++)
                    advance_key(i, rq.now, rq.levels);
            REQ_GET:
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (rq.upd)
                        advance_key(i, rq.now, rq.levels);
                    if (tbl_phase[i] == PH_PRESSED)
                    begin
                        tbl_phase[i] = PH_REST;
                        rp.found = 1'b1;
                        rp.code = tbl_code[i];
                        break;
                    end
                end
            default:
                ;
        endcase
        return rp;
    endfunction

    function automatic key_request_t build_request(logic [1:0] req, logic [7:0] code,
        logic [2:0] row, logic [2:0] column, logic upd, logic [31:0] now, logic [63:0] levels);
        key_request_t r;
        r.req = req;
        r.code = code;
        r.row = row;
        r.column = column;
        r.upd = upd;
        r.now = now;
        r.levels = levels;
        r.hold = 1'b0;
        return r;
    endfunction

    // Levels drift a bit per request so keys stay down across several scans.
    function automatic key_request_t random_request();
        key_request_t r;
        logic [31:0]  step;
        int unsigned  pick;
        int           idx;
        pick = $urandom_range(0, 99);
        if (gen_keys > 0 && $urandom_range(0, 1) == 1)
        begin
            idx = gen_spot[$urandom_range(0, gen_keys - 1)];
            levels_now[idx] = ~levels_now[idx];
        end
        if ($urandom_range(0, 3) == 0)
        begin
            idx = $urandom_range(0, 63);
            levels_now[idx] = ~levels_now[idx];
        end
        case ($urandom_range(0, 3))
            0: step = $urandom_range(0, dbn_ms / 4 + 1);
            1: step = {16'd0, dbn_ms} + $urandom_range(0, 2) - 1;
            2: step = $urandom_range(0, 3 * dbn_ms + 3);
            default: step = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 8);
        endcase
        sim_ms = sim_ms + step;
        r = build_request(REQ_UPDATE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), sim_ms, levels_now);
        if (pick < 8)
            r.req = REQ_ADD;
        else if (pick < 52)
            r.req = REQ_UPDATE;
        else if (pick < 92)
            r.req = REQ_GET;
        else if (pick < 95)
            r.req = REQ_UNUSED;
        else
        begin
            r.req = pick[0] ? REQ_UPDATE : REQ_GET;
            r.levels = {$urandom, $urandom};
        end
        r.hold = ($urandom_range(0, 39) == 0);
        return r;
    endfunction

    task automatic queue_request(key_request_t r);
        if (r.req == REQ_ADD && gen_keys < MAX_KEYS)
        begin
            gen_spot[gen_keys] = {r.row, r.column};
            gen_keys++;
        end
        requests_waiting.push_back(r);
        requests_queued++;
    endtask

    task automatic wait_for_replies();
        while (replies_seen < requests_queued)
            @(negedge clk);
    endtask

    task automatic set_debounce(logic [15:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dbn_ms = v;
    endtask

    task automatic run_phase(int count, bit send_idle, bit recv_idle);
        key_request_t rq;
        @(posedge clk);
        send_idle_on = send_idle;
        recv_idle_on = recv_idle;
        for (int n = 0; n < count; n++)
        begin
            rq = random_request();
            if (n == count / 2)
                rq.hold = 1'b1;
            queue_request(rq);
        end
        wait_for_replies();
    endtask

    // request driver
    always @(negedge clk)
    begin
        logic         next_valid;
        key_request_t cur;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (req_taken)
            begin
                next_valid = 1'b0;
                send_wait = send_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            end
            if (!next_valid)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (requests_waiting.size() > 0 &&
                         (!requests_waiting[0].hold || replies_due.size() == 0))
                begin
                    cur = requests_waiting.pop_front();
                    req_type <= cur.req;
                    new_key_code <= cur.code;
                    new_key_row <= cur.row;
                    new_key_column <= cur.column;
                    update_first <= cur.upd;
                    now_ms <= cur.now;
                    line_levels <= cur.levels;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
    end

    // reply acceptor
    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = out_ready;
        if (rst_n)
        begin
            if (reply_taken)
                recv_wait = recv_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (recv_wait > 0)
            begin
                recv_wait--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
        end
        out_ready <= next_ready;
    end

    // beat monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        key_request_t rq;
        key_reply_t   got;
        key_reply_t   want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            reply_taken <= 1'b0;
        end
        else
        begin
            req_taken <= in_valid && in_ready;
            reply_taken <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                replies_seen++;
                got.added = add_accepted;
                got.found = key_found;
                got.code = found_code;
                if (replies_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected reply: added=%0d found=%0d code=%02h",
                            got.added, got.found, got.code);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.added !== want.added || got.found !== want.found ||
                        got.code !== want.code)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("reply %0d: exp added=%0d found=%0d code=%02h, got added=%0d found=%0d code=%02h",
                                replies_seen, want.added, want.found, want.code,
                                got.added, got.found, got.code);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                rq = build_request(req_type, new_key_code, new_key_row, new_key_column,
                    update_first, now_ms, line_levels);
                want = serve_request(rq);
                replies_due.push_back(want);
                adds_taken += want.added;
                presses_returned += want.found;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                    quiet, replies_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // empty table, unused code
        queue_request(build_request(REQ_GET, 8'hFF, 3'd7, 3'd7, 1'b1, 32'd0, '1));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'd5, '1));
        queue_request(build_request(REQ_UNUSED, 8'hFF, 3'd7, 3'd7, 1'b1, '1, '1));
        // corner keys, plus a second key sharing the first position
        queue_request(build_request(REQ_ADD, 8'h00, 3'd0, 3'd0, 1'b0, 32'd0, '0));
        queue_request(build_request(REQ_ADD, 8'hFF, 3'd7, 3'd7, 1'b1, '1, '1));
        queue_request(build_request(REQ_ADD, 8'hA5, 3'd0, 3'd7, 1'b0, 32'd0, '0));
        queue_request(build_request(REQ_ADD, 8'h5A, 3'd7, 3'd0, 1'b1, 32'd0, '0));
        queue_request(build_request(REQ_ADD, 8'h3C, 3'd3, 3'd5, 1'b0, 32'd0, '0));
        queue_request(build_request(REQ_ADD, 8'h81, 3'd0, 3'd0, 1'b0, 32'd0, '0));
        // press with the timeout boundary exactly at debounce, then one past
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1000, 64'h1));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1050, 64'h1));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1051, 64'h1));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1055, 64'h1));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1060, 64'h0));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1061, 64'h0));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1062, 64'h0));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b0, 32'd1063, 64'h0));
        // timeout across the 32-bit wrap, release seen inside the search
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'hFFFF_FFF0,
            64'h8000_0000_0000_0000));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'h0000_0023,
            64'h8000_0000_0000_0000));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b1, 32'h0000_0030, 64'h0));
        // bounce: clamped then released before the timeout
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'h0000_0040, 64'h80));
        queue_request(build_request(REQ_UPDATE, 8'h00, 3'd0, 3'd0, 1'b0, 32'h0000_0045, 64'h0));
        queue_request(build_request(REQ_GET, 8'h00, 3'd0, 3'd0, 1'b1, 32'h0000_0050, '1));
        sim_ms = 32'h0000_0050;

        run_phase(RANDOM_PER_PHASE, 1'b1, 1'b1);
        set_debounce(16'd0);
        run_phase(RANDOM_PER_PHASE, 1'b0, 1'b0);
        set_debounce(16'hFFFF);
        sim_ms = 32'hFFFF_0000;
        run_phase(RANDOM_PER_PHASE, 1'b1, 1'b0);
        set_debounce(16'($urandom_range(1, 400)));
        run_phase(RANDOM_PER_PHASE, 1'b0, 1'b1);
        set_debounce(16'($urandom_range(0, 65535)));
        run_phase(RANDOM_PER_PHASE, 1'b1, 1'b1);

        repeat (24) @(negedge clk);
        if (replies_due.size() != 0)
        begin
            $display("%0d replies never arrived", replies_due.size());
            errors += replies_due.size();
        end
        $display("%0d requests over five debounce settings (reset value, 0, 65535, two drawn)",
            requests_queued);
        $display("%0d keys added, %0d pressed keys returned, %0d errors",
            adds_taken, presses_returned, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
